// ----- sv/rvc_pkg.sv -----
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared types and codes for the RV32I step core.
// ----------------------------------------------------------------------------
package rvc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FETCH = 2'd1,
    PH_LOAD  = 2'd2,
    PH_STORE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_EXEC  = 2'd1,
    ST_CLEAR = 2'd2
  } ctl_state_t;

  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_ILLEGAL  = 3'd1;
  localparam logic [2:0] FLT_MISALIGN = 3'd2;
  localparam logic [2:0] FLT_BUS      = 3'd3;
  localparam logic [2:0] FLT_BREAK    = 3'd4;
  localparam logic [2:0] FLT_ECALL    = 3'd5;

  localparam logic [1:0] KIND_FETCH = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_STORE = 2'd2;

  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_ADD_PC  = 7'h17;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_BRCOND  = 7'h63;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STMEM   = 7'h23;
  localparam logic [6:0] OPC_IMM     = 7'h13;
  localparam logic [6:0] OPC_REG     = 7'h33;
  localparam logic [6:0] OPC_MEMORD  = 7'h0F;
  localparam logic [6:0] OPC_SYS     = 7'h73;

  localparam logic [31:0] ECALL_EXIT = 32'd93;
  localparam logic [4:0]  REG_A7     = 5'd17;

  // result item
  typedef struct packed {
    logic [63:0] retired;
    logic [2:0]  fault;
    logic        halted;
    logic [31:0] req_write_data;
    logic [1:0]  req_size;
    logic [31:0] req_address;
    logic [1:0]  req_kind;
    logic        req_valid;
  } result_t;

endpackage

// ----- sv/rvc_ram.sv -----
// ----------------------------------------------------------------------------
// rvc_ram
// Generic single write, single registered read port RAM.
// ----------------------------------------------------------------------------
module rvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/rv32i_core_step_top.sv -----
// ----------------------------------------------------------------------------
// rv32i_core_step_top
// RV32I core stepped by bus response items over a stream interface.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per step. tuser = func (0 start, 1 bus response),
//           tdata = {bus_error, read_data}.
//   out_* : exactly one result item per input item, carrying the next bus
//           request plus halted, fault and retired count.
//   cfg_* : writes entry_address; write only while the core is idle.
// Timing: an item is taken and its operands are read from the register
// file RAMs (two copies, one registered read port each) in the next cycle;
// the result is registered once the output register is free. The core
// takes no new item until the result of the last one is registered.
// A result waits in the output register while the receiver stalls; the
// next item may be accepted meanwhile, its result is held back until the
// register frees.
// After reset, and after every start item, the core sweeps the register
// file to zero, one entry per cycle, before taking a new item.
// ----------------------------------------------------------------------------
module rv32i_core_step_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] read_data, [32] bus_error
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [143:0] out_tdata, // [0] req_valid, [2:1] req_kind,
                                  // [34:3] req_address, [36:35] req_size,
                                  // [68:37] req_write_data, [69] halted,
                                  // [72:70] fault, [136:73] retired
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import rvc_pkg::*;

  ctl_state_t  st_r, st_nxt;
  logic [31:0] entry_r, pc_r;
  phase_t      phase_r;
  logic [4:0]  pdest_r, clr_r;
  logic [2:0]  pkind_r, fault_r;
  logic        halted_r;
  logic [63:0] ret_r;
  logic [31:0] data_r;
  logic        func_r, err_r;
  result_t     res_r;
  logic        ovalid_r;
  logic [4:0]  rs1_r, rs2_r;

  logic        in_acc;
  logic        fire;
  logic        we;
  logic [4:0]  waddr;
  logic [31:0] wdata;
  logic [31:0] a_q, b_q, a, b;
  logic [4:0]  rs1, rs2;

  // result register frees when taken or empty
  logic out_free;
  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (st_r == ST_READY);
  assign in_acc    = in_tvalid && in_tready;
  assign fire      = (st_r == ST_EXEC) && out_free;
  assign cfg_ready = 1'b1;

  // read addresses held while the item waits for the output register
  assign rs1 = in_acc ? in_tdata[19:15] : rs1_r;
  assign rs2 = in_acc ? in_tdata[24:20] : rs2_r;

  // two read copies of the register file
  rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rs1), .rdata(a_q));
  rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rs2), .rdata(b_q));

  // x0 may hold a stale value only if never written; force zero on read
  logic [31:0] x17_r;
  assign a = (rs1_r == 5'd0) ? 32'd0 : a_q;
  assign b = (rs2_r == 5'd0) ? 32'd0 : b_q;

  // decode
  logic [31:0] ir;
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic        alt;
  logic [31:0] immi, imms, immb, immj, immu, npc, pc4, r, addr;
  logic        taken;
  assign ir   = data_r;
  assign op   = ir[6:0];
  assign rd   = ir[11:7];
  assign f3   = ir[14:12];
  assign alt  = ir[30];
  assign immi = {{20{ir[31]}}, ir[31:20]};
  assign imms = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  assign immb = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  assign immj = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
  assign immu = {ir[31:12], 12'd0};
  assign pc4  = pc_r + 32'd4;

  logic [31:0] opb;
  logic [4:0]  sh;
  logic        slt, sltu;
  assign opb  = (op == OPC_REG) ? b : immi;
  assign sh   = opb[4:0];
  assign slt  = $signed(a) < $signed(opb);
  assign sltu = a < opb;

  always_comb begin
    unique case (f3)
      3'd0: r = (op == OPC_REG && alt) ? a - opb : a + opb;
      3'd1: r = a << sh;
      3'd2: r = {31'd0, slt};
      3'd3: r = {31'd0, sltu};
      3'd4: r = a ^ opb;
      3'd5: r = alt ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: r = a | opb;
      default: r = a & opb;
    endcase
  end

  always_comb begin
    unique case (f3)
      3'd0: taken = (a == b);
      3'd1: taken = (a != b);
      3'd4: taken = $signed(a) < $signed(b);
      3'd5: taken = !($signed(a) < $signed(b));
      3'd6: taken = a < b;
      default: taken = a >= b;
    endcase
  end

  logic [31:0] ldv;
  always_comb begin
    unique case (pkind_r)
      3'd0: ldv = {{24{data_r[7]}}, data_r[7:0]};
      3'd1: ldv = {{16{data_r[15]}}, data_r[15:0]};
      3'd4: ldv = {24'd0, data_r[7:0]};
      3'd5: ldv = {16'd0, data_r[15:0]};
      default: ldv = data_r;
    endcase
  end

  // step evaluation
  result_t     res;
  phase_t      phase_n;
  logic [31:0] pc_n;
  logic [4:0]  pdest_n;
  logic [2:0]  pkind_n, fault_n;
  logic        halted_n, retire, do_halt, start;
  logic [2:0]  hcode;
  logic        rwe;
  logic [31:0] rval;

  always_comb begin
    res      = '0;
    phase_n  = phase_r;
    pc_n     = pc_r;
    pdest_n  = pdest_r;
    pkind_n  = pkind_r;
    fault_n  = fault_r;
    halted_n = halted_r;
    retire   = 1'b0;
    do_halt  = 1'b0;
    start    = 1'b0;
    hcode    = FLT_NONE;
    rwe      = 1'b0;
    rval     = 32'd0;
    npc      = pc4;
    addr     = 32'd0;
    if (!func_r) begin
      start    = 1'b1;
      pc_n     = entry_r;
      pdest_n  = '0;
      pkind_n  = '0;
      fault_n  = FLT_NONE;
      halted_n = 1'b0;
    end else if (halted_r || phase_r == PH_IDLE) begin
      // ignored
    end else if (err_r) begin
      do_halt = 1'b1; hcode = FLT_BUS;
    end else if (phase_r == PH_LOAD) begin
      rwe = 1'b1; rval = ldv; retire = 1'b1;
    end else if (phase_r == PH_STORE) begin
      retire = 1'b1;
    end else begin
      unique case (op)
        OPC_LUI:    begin rwe = 1'b1; rval = immu; retire = 1'b1; end
        OPC_ADD_PC: begin rwe = 1'b1; rval = pc_r + immu; retire = 1'b1; end
        OPC_JAL: begin
          rwe = 1'b1; rval = pc4; npc = pc_r + immj; retire = 1'b1;
        end
        OPC_JALR: begin
          rwe = 1'b1; rval = pc4; retire = 1'b1;
          npc = (a + immi) & ~32'd1;
        end
        OPC_BRCOND: begin
          if (f3 == 3'd2 || f3 == 3'd3) begin
            do_halt = 1'b1; hcode = FLT_ILLEGAL;
          end else begin
            retire = 1'b1;
            if (taken) npc = pc_r + immb;
          end
        end
        OPC_LOAD: begin
          if (f3 == 3'd3 || f3 > 3'd5) begin
            do_halt = 1'b1; hcode = FLT_ILLEGAL;
          end else begin
            addr = a + immi;
            pdest_n = rd; pkind_n = f3; phase_n = PH_LOAD;
            res.req_valid = 1'b1; res.req_kind = KIND_LOAD;
            res.req_address = addr; res.req_size = f3[1:0];
          end
        end
        OPC_STMEM: begin
          if (f3 > 3'd2) begin
            do_halt = 1'b1; hcode = FLT_ILLEGAL;
          end else begin
            addr = a + imms;
            phase_n = PH_STORE;
            res.req_valid = 1'b1; res.req_kind = KIND_STORE;
            res.req_address = addr; res.req_size = f3[1:0];
            res.req_write_data = b;
          end
        end
        OPC_IMM: begin rwe = 1'b1; rval = r; retire = 1'b1; end
        OPC_REG: begin
          if (alt && f3 != 3'd0 && f3 != 3'd5) begin
            do_halt = 1'b1; hcode = FLT_ILLEGAL;
          end else begin
            rwe = 1'b1; rval = r; retire = 1'b1;
          end
        end
        OPC_MEMORD: retire = 1'b1;
        OPC_SYS: begin
          if (immi == 32'd0) begin
            fault_n = FLT_ECALL;
            if (x17_r == ECALL_EXIT) begin
              do_halt = 1'b1; hcode = FLT_ECALL;
            end else begin
              retire = 1'b1;
            end
          end else begin
            do_halt = 1'b1; hcode = FLT_BREAK;
          end
        end
        default: begin do_halt = 1'b1; hcode = FLT_ILLEGAL; end
      endcase
    end
    if (retire) begin
      pc_n = (phase_r == PH_FETCH) ? npc : pc4;
    end
    if (start || retire) begin
      if (pc_n[1:0] != 2'd0) begin
        do_halt = 1'b1; hcode = FLT_MISALIGN;
      end else begin
        phase_n = PH_FETCH;
        res.req_valid = 1'b1; res.req_kind = KIND_FETCH;
        res.req_address = pc_n; res.req_size = SIZE_WORD;
      end
    end
    if (do_halt) begin
      halted_n = 1'b1; fault_n = hcode; phase_n = PH_IDLE;
      res = '0;
    end
    res.halted  = halted_n;
    res.fault   = fault_n;
    res.retired = start ? 64'd0 : ret_r + {63'd0, retire};
  end

  // register file write: clear sweep or writeback (writeback never writes x0)
  logic [4:0] wb_rd;
  assign wb_rd = (phase_r == PH_LOAD) ? pdest_r : rd;
  assign we    = (st_r == ST_CLEAR) || (fire && rwe && !do_halt && wb_rd != 5'd0);
  assign waddr = (st_r == ST_CLEAR) ? clr_r : wb_rd;
  assign wdata = (st_r == ST_CLEAR) ? 32'd0 : rval;

  // control sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_READY: if (in_acc) st_nxt = ST_EXEC;
      ST_EXEC:  if (fire) st_nxt = start ? ST_CLEAR : ST_READY;
      ST_CLEAR: if (clr_r == 5'd31) st_nxt = ST_READY;
      default:  st_nxt = ST_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLEAR;
      clr_r    <= '0;
      entry_r  <= '0;
      pc_r     <= '0;
      phase_r  <= PH_IDLE;
      pdest_r  <= '0;
      pkind_r  <= '0;
      fault_r  <= FLT_NONE;
      halted_r <= 1'b0;
      ret_r    <= '0;
      ovalid_r <= 1'b0;
      x17_r    <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) entry_r <= cfg_data;
      if (st_r == ST_CLEAR) clr_r <= clr_r + 5'd1;
      else clr_r <= '0;
      if (fire) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (fire) begin
        pc_r     <= pc_n;
        phase_r  <= phase_n;
        pdest_r  <= pdest_n;
        pkind_r  <= pkind_n;
        fault_r  <= fault_n;
        halted_r <= halted_n;
        ret_r    <= res.retired;
        if (start) x17_r <= '0;
        else if (we && waddr == REG_A7) x17_r <= wdata;
      end
    end
  end

  // item payload capture and result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r <= in_tdata[31:0];
      err_r  <= in_tdata[32];
      func_r <= in_tuser;
      rs1_r  <= rs1;
      rs2_r  <= rs2;
    end
    if (fire) res_r <= res;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, res_r.retired, res_r.fault, res_r.halted,
                       res_r.req_write_data, res_r.req_size, res_r.req_address,
                       res_r.req_kind, res_r.req_valid};
endmodule
